/* rtl/queue_machine_execute_unit_defines.svh */
// Assertion macros for the queue machine execute unit.
`ifndef QUEUE_MACHINE_EXECUTE_UNIT_DEFINES_SVH
`define QUEUE_MACHINE_EXECUTE_UNIT_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define QMEU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define QMEU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/qmeu_pkg.sv */
package qmeu_pkg;

  localparam int unsigned QueueDepthDef = 256;
  localparam int unsigned NumRegsDef    = 26;

  localparam int unsigned DataW = 16;
  localparam int unsigned ModeW = 5;
  localparam int unsigned RegW  = 5;
  localparam int unsigned KindW = 2;
  localparam int unsigned ErrW  = 2;

  localparam logic [ModeW-1:0] OpPush        = 5'd0;
  localparam logic [ModeW-1:0] OpAdd         = 5'd1;
  localparam logic [ModeW-1:0] OpSub         = 5'd2;
  localparam logic [ModeW-1:0] OpMul         = 5'd3;
  localparam logic [ModeW-1:0] OpDiv         = 5'd4;
  localparam logic [ModeW-1:0] OpMod         = 5'd5;
  localparam logic [ModeW-1:0] OpSetReg      = 5'd6;
  localparam logic [ModeW-1:0] OpGetReg      = 5'd7;
  localparam logic [ModeW-1:0] OpPrint       = 5'd8;
  localparam logic [ModeW-1:0] OpPrintReg    = 5'd9;
  localparam logic [ModeW-1:0] OpPrintChr    = 5'd10;
  localparam logic [ModeW-1:0] OpPrintRegChr = 5'd11;
  localparam logic [ModeW-1:0] OpJmp         = 5'd12;
  localparam logic [ModeW-1:0] OpJz          = 5'd13;
  localparam logic [ModeW-1:0] OpJe          = 5'd14;
  localparam logic [ModeW-1:0] OpJg          = 5'd15;
  localparam logic [ModeW-1:0] OpQuit        = 5'd16;

  localparam logic [KindW-1:0] KindNone = 2'd0;
  localparam logic [KindW-1:0] KindNum  = 2'd1;
  localparam logic [KindW-1:0] KindChr  = 2'd2;

  localparam logic [ErrW-1:0] ErrOk    = 2'd0;
  localparam logic [ErrW-1:0] ErrUnder = 2'd1;
  localparam logic [ErrW-1:0] ErrOver  = 2'd2;

  // ALU selection for the result pushed back to the queue
  typedef enum logic [2:0] {
    AluImm, AluAdd, AluSub, AluMul, AluDiv, AluMod, AluReg
  } alu_sel_e;

  // controller -> datapath
  typedef struct packed {
    logic     cap_in;    // capture the input item
    logic     rd_pop;    // read queue at head, advance head
    logic     lat_x;     // latch popped value as x
    logic     lat_y;     // latch popped value as y
    logic     div_start;
    logic     push;      // write result at tail
    alu_sel_e alu_sel;
    logic     reg_wr;    // write popped value to register
    logic     out_load;  // load result register
  } qmeu_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic             q_empty;
    logic             q_lt2;
    logic             q_full;
    logic             div_busy;
  } qmeu_sts_t;

endpackage

/* rtl/qmeu_ram.sv */
module qmeu_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

/* rtl/qmeu_div.sv */
// Restoring divider, one quotient bit per cycle.
module qmeu_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [qmeu_pkg::DataW-1:0] dividend_i,
  input  logic [qmeu_pkg::DataW-1:0] divisor_i,
  output logic                   busy_o,
  output logic [qmeu_pkg::DataW-1:0] quot_o,
  output logic [qmeu_pkg::DataW-1:0] rem_o
);
  import qmeu_pkg::*;

  localparam int unsigned CntW = $clog2(DataW + 1);

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DataW-1:0] quot_q, quot_d;
  logic [DataW:0]   rem_q, rem_d;
  logic [DataW-1:0] dvs_q, dvs_d;
  logic [DataW:0]   trial;

  always_comb begin
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    trial  = {rem_q[DataW-1:0], quot_q[DataW-1]} - {1'b0, dvs_q};
    if (start_i) begin
      cnt_d  = CntW'(DataW);
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (!trial[DataW]) begin
        rem_d  = trial;
        quot_d = {quot_q[DataW-2:0], 1'b1};
      end else begin
        rem_d  = {rem_q[DataW-1:0], quot_q[DataW-1]};
        quot_d = {quot_q[DataW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign busy_o = (cnt_q != '0);
  // divide by zero gives 0 for both
  assign quot_o = (dvs_q == '0) ? '0 : quot_q;
  assign rem_o  = (dvs_q == '0) ? '0 : rem_q[DataW-1:0];
endmodule

/* rtl/qmeu_datapath.sv */
module qmeu_datapath #(
  parameter int unsigned QueueDepth = qmeu_pkg::QueueDepthDef,
  parameter int unsigned NumRegs    = qmeu_pkg::NumRegsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  qmeu_pkg::qmeu_cmd_t         cmd_i,
  output qmeu_pkg::qmeu_sts_t         sts_o,
  input  logic [qmeu_pkg::ModeW-1:0]  mode_i,
  input  logic [qmeu_pkg::RegW-1:0]   reg_first_i,
  input  logic [qmeu_pkg::RegW-1:0]   reg_second_i,
  input  logic [qmeu_pkg::DataW-1:0]  immediate_i,
  output logic [qmeu_pkg::KindW-1:0]  print_kind_o,
  output logic [qmeu_pkg::DataW-1:0]  print_value_o,
  output logic                        branch_taken_o,
  output logic                        halt_o,
  output logic [qmeu_pkg::ErrW-1:0]   error_o
);
  import qmeu_pkg::*;

  localparam int unsigned AddrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW  = $clog2(QueueDepth + 1);

  logic [ModeW-1:0] mode_q;
  logic [RegW-1:0]  ra_q, rb_q;
  logic [DataW-1:0] imm_q;
  logic [AddrW-1:0] head_q;
  logic [CntW-1:0]  count_q;
  logic [DataW-1:0] x_q, y_q, prod_q;
  logic [DataW-1:0] regs_q [NumRegs];
  logic [DataW-1:0] ram_rdata, push_val, rega, regb;
  logic [CntW:0]    tail_sum;
  logic [AddrW-1:0] tail;
  logic             div_busy;
  logic [DataW-1:0] quot, rem;
  logic [KindW-1:0] kind_d;
  logic [DataW-1:0] value_d;
  logic             br_d, halt_d;
  logic [ErrW-1:0]  err_d;
  logic             under, over;

  assign rega = (ra_q < RegW'(NumRegs)) ? regs_q[ra_q] : '0;
  assign regb = (rb_q < RegW'(NumRegs)) ? regs_q[rb_q] : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      mode_q <= mode_i;
      ra_q   <= reg_first_i;
      rb_q   <= reg_second_i;
      imm_q  <= immediate_i;
    end
    if (cmd_i.lat_x) x_q <= ram_rdata;
    if (cmd_i.lat_y) y_q <= ram_rdata;
    prod_q <= DataW'(x_q * y_q);
  end

  // head + count wraps at the queue depth, which need not be a power of two
  assign tail_sum = (CntW+1)'(head_q) + (CntW+1)'(count_q);
  assign tail     = (tail_sum >= (CntW+1)'(QueueDepth)) ?
                    AddrW'(tail_sum - (CntW+1)'(QueueDepth)) : AddrW'(tail_sum);

  always_comb begin
    case (cmd_i.alu_sel)
      AluImm:  push_val = imm_q;
      AluAdd:  push_val = x_q + y_q;
      AluSub:  push_val = x_q - y_q;
      AluMul:  push_val = prod_q;
      AluDiv:  push_val = quot;
      AluMod:  push_val = rem;
      AluReg:  push_val = rega;
      default: push_val = '0;
    endcase
  end

  qmeu_ram #(.Width(DataW), .Depth(QueueDepth)) u_queue (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (tail),
    .wdata_i (push_val),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  qmeu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (x_q),
    .divisor_i  (y_q),
    .busy_o     (div_busy),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      for (int i = 0; i < NumRegs; i++) regs_q[i] <= '0;
    end else begin
      if (cmd_i.rd_pop) begin
        head_q <= (head_q == AddrW'(QueueDepth - 1)) ? '0 : head_q + 1'b1;
      end
      count_q <= count_q + CntW'(cmd_i.push) - CntW'(cmd_i.rd_pop);
      if (cmd_i.reg_wr && ra_q < RegW'(NumRegs)) regs_q[ra_q] <= ram_rdata;
    end
  end

  assign sts_o.mode     = mode_q;
  assign sts_o.q_empty  = (count_q == '0);
  assign sts_o.q_lt2    = (count_q < CntW'(2));
  assign sts_o.q_full   = (count_q == CntW'(QueueDepth));
  assign sts_o.div_busy = div_busy;

  // result for the item; the pop data is valid in the cycle it is used
  always_comb begin
    kind_d  = KindNone;
    value_d = '0;
    br_d    = 1'b0;
    halt_d  = 1'b0;
    under   = 1'b0;
    over    = 1'b0;
    case (mode_q)
      OpPush, OpGetReg: over = (count_q == CntW'(QueueDepth));
      OpAdd, OpSub, OpMul, OpDiv, OpMod: under = 1'b0;
      OpSetReg: under = 1'b0;
      OpPrint: begin
        kind_d  = KindNum;
        value_d = ram_rdata;
      end
      OpPrintReg: begin
        kind_d  = KindNum;
        value_d = rega;
      end
      OpPrintChr: begin
        kind_d  = KindChr;
        value_d = {8'd0, ram_rdata[7:0]};
      end
      OpPrintRegChr: begin
        kind_d  = KindChr;
        value_d = {8'd0, rega[7:0]};
      end
      OpJmp:   br_d = 1'b1;
      OpJz:    br_d = (rega == '0);
      OpJe:    br_d = (rega == regb);
      OpJg:    br_d = (rega > regb);
      OpQuit:  halt_d = 1'b1;
      default: halt_d = 1'b0;
    endcase
    case (mode_q)
      OpAdd, OpSub, OpMul, OpDiv, OpMod: under = (count_q < CntW'(2));
      OpSetReg, OpPrint, OpPrintChr:     under = (count_q == '0);
      default:                           under = under;
    endcase
    err_d = under ? ErrUnder : (over ? ErrOver : ErrOk);
    if (under) begin
      kind_d  = KindNone;
      value_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      print_kind_o   <= kind_d;
      print_value_o  <= value_d;
      branch_taken_o <= br_d;
      halt_o         <= halt_d;
      error_o        <= err_d;
    end
  end
endmodule

/* rtl/qmeu_ctrl.sv */
module qmeu_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  qmeu_pkg::qmeu_sts_t sts_i,
  output qmeu_pkg::qmeu_cmd_t cmd_o
);
  import qmeu_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StDecode, StPopY, StWaitY, StCalc, StDivWait, StPush, StOut
  } state_e;

  state_e   state_q;
  logic     out_valid_q;
  alu_sel_e sel;
  logic     two_op, pop_one;

  assign in_ready_o  = (state_q == StIdle) && !out_valid_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    case (sts_i.mode)
      OpAdd:   sel = AluAdd;
      OpSub:   sel = AluSub;
      OpMul:   sel = AluMul;
      OpDiv:   sel = AluDiv;
      OpMod:   sel = AluMod;
      OpGetReg: sel = AluReg;
      default: sel = AluImm;
    endcase
    two_op  = (sts_i.mode == OpAdd) || (sts_i.mode == OpSub) || (sts_i.mode == OpMul) ||
              (sts_i.mode == OpDiv) || (sts_i.mode == OpMod);
    pop_one = (sts_i.mode == OpSetReg) || (sts_i.mode == OpPrint) ||
              (sts_i.mode == OpPrintChr);
  end

  // Two-operand ops: StDecode reads x, StPopY reads y, StWaitY latches y,
  // StCalc (mul product / div start), StPush or StDivWait writes. Head RAM
  // read is registered. The result register is loaded in StDecode, while the
  // queue count is still the one the item saw.
  always_comb begin
    cmd_o          = '0;
    cmd_o.alu_sel  = sel;
    cmd_o.cap_in   = in_valid_i && in_ready_o;
    case (state_q)
      StDecode: begin
        if (two_op && !sts_i.q_lt2) begin
          cmd_o.rd_pop   = 1'b1;
          cmd_o.out_load = 1'b1;
        end else if (pop_one && !sts_i.q_empty) begin
          cmd_o.rd_pop   = 1'b1;
          cmd_o.out_load = 1'b1;
          cmd_o.reg_wr   = (sts_i.mode == OpSetReg);
        end else begin
          cmd_o.out_load = 1'b1;
          cmd_o.push     = ((sts_i.mode == OpPush) || (sts_i.mode == OpGetReg)) &&
                           !sts_i.q_full;
        end
      end
      StPopY: begin
        cmd_o.lat_x  = 1'b1;
        cmd_o.rd_pop = 1'b1;
      end
      StWaitY:   cmd_o.lat_y = 1'b1;
      StCalc:    cmd_o.div_start = (sts_i.mode == OpDiv) || (sts_i.mode == OpMod);
      StPush:    cmd_o.push = 1'b1;
      StDivWait: cmd_o.push = !sts_i.div_busy;
      default:   cmd_o.rd_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        StIdle: if (cmd_o.cap_in) state_q <= StDecode;
        StDecode: begin
          if (two_op && !sts_i.q_lt2) begin
            state_q <= StPopY;
          end else begin
            state_q     <= StIdle;
            out_valid_q <= 1'b1;
          end
        end
        StPopY:  state_q <= StWaitY;
        StWaitY: state_q <= StCalc;
        StCalc: begin
          state_q <= ((sts_i.mode == OpDiv) || (sts_i.mode == OpMod)) ? StDivWait : StPush;
        end
        StDivWait: if (!sts_i.div_busy) state_q <= StOut;
        StPush:  state_q <= StOut;
        StOut:   state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
      if (state_q == StOut) out_valid_q <= 1'b1;
    end
  end
endmodule

/* rtl/queue_machine_execute_unit.sv */
// One-step instructions finish in StDecode; add/sub/mul go on through StPopY, StWaitY,
// StCalc, StPush and StOut; div and mod wait on the shared divider in StDivWait instead.
// One item at a time: s_axis_tready rises again in the cycle after the result is taken.
// Reset (async, active low) clears queue head/count, the register file and the controller.
module queue_machine_execute_unit #(
  parameter int unsigned QueueDepth = qmeu_pkg::QueueDepthDef,
  parameter int unsigned NumRegs    = qmeu_pkg::NumRegsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // mode[4:0], reg_first[9:5], reg_second[14:10],
                                     // immediate[30:15], zero[31]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // print_value[15:0], branch_taken[16], halt[17],
                                     // error[19:18], zero[23:20]
  output logic [1:0]  m_axis_tuser   // print_kind[1:0]
);
  import qmeu_pkg::*;

  qmeu_cmd_t        cmd;
  qmeu_sts_t        sts;
  logic [KindW-1:0] kind;
  logic [DataW-1:0] value;
  logic             br, hlt;
  logic [ErrW-1:0]  err;

  qmeu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  qmeu_datapath #(.QueueDepth(QueueDepth), .NumRegs(NumRegs)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .mode_i         (s_axis_tdata[4:0]),
    .reg_first_i    (s_axis_tdata[9:5]),
    .reg_second_i   (s_axis_tdata[14:10]),
    .immediate_i    (s_axis_tdata[30:15]),
    .print_kind_o   (kind),
    .print_value_o  (value),
    .branch_taken_o (br),
    .halt_o         (hlt),
    .error_o        (err)
  );

  assign m_axis_tdata = {4'd0, err, hlt, br, value};
  assign m_axis_tuser = kind;
endmodule

/* rtl/qmeu_checker.sv */
module qmeu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  `include "queue_machine_execute_unit_defines.svh"

  `QMEU_ASSERT_IMP(a_no_accept_while_out, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready, "accept while result pending")
  `QMEU_ASSERT_NEXT(a_out_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !m_axis_tvalid, "result too early")
  `QMEU_ASSERT_IMP(a_err_quiet, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[19:18] != 2'd0, m_axis_tuser == 2'd0 && !m_axis_tdata[16] && !m_axis_tdata[17], "error with action")
  `QMEU_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped")
endmodule

bind queue_machine_execute_unit qmeu_checker u_qmeu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* tb/sv/queue_machine_execute_unit_tb.sv */
module queue_machine_execute_unit_tb;
  import qmeu_pkg::*;

  localparam int unsigned QDepth = 256;
  localparam int unsigned NRegs  = 26;
  localparam logic [ModeW-1:0] OpLabel = 5'd17;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [15:0]      value;
    logic             branch;
    logic             halt;
    logic [ErrW-1:0]  err;
  } outcome_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  queue_machine_execute_unit dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  // predictor state
  logic [15:0] operands[$];
  logic [15:0] regs[NRegs];
  outcome_t    pending_outcomes[$];
  int          fail_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [15:0] reg_value(logic [4:0] idx);
    if (idx < NRegs) return regs[idx];
    return 16'd0;
  endfunction

  function automatic outcome_t execute_instr(logic [4:0] mode, logic [4:0] ra, logic [4:0] rb,
                                             logic [15:0] imm);
    outcome_t o;
    logic [15:0] x, y, r;
    o = '0;
    case (mode)
      OpPush, OpGetReg: begin
        if (operands.size() >= QDepth) o.err = ErrOver;
        else operands = {operands, ((mode == OpPush) ? imm : reg_value(ra))};
      end
      OpAdd, OpSub, OpMul, OpDiv, OpMod: begin
        if (operands.size() < 2) o.err = ErrUnder;
        else begin
          x = operands.pop_front();
          y = operands.pop_front();
          case (mode)
            OpAdd: r = x + y;
            OpSub: r = x - y;
            OpMul: r = x * y;
            OpDiv: r = (y == 0) ? 16'd0 : x / y;
            default: r = (y == 0) ? 16'd0 : x % y;
          endcase
          operands = {operands, r};
        end
      end
      OpSetReg: begin
        if (operands.size() == 0) o.err = ErrUnder;
        else begin
          x = operands.pop_front();
          if (ra < NRegs) regs[ra] = x;
        end
      end
      OpPrint, OpPrintChr: begin
        if (operands.size() == 0) o.err = ErrUnder;
        else begin
          x = operands.pop_front();
          o.kind = (mode == OpPrint) ? KindNum : KindChr;
          o.value = (mode == OpPrint) ? x : {8'd0, x[7:0]};
        end
      end
      OpPrintReg: begin
        o.kind = KindNum;
        o.value = reg_value(ra);
      end
      OpPrintRegChr: begin
        x = reg_value(ra);
        o.kind = KindChr;
        o.value = {8'd0, x[7:0]};
      end
      OpJmp: o.branch = 1'b1;
      OpJz: o.branch = (reg_value(ra) == 0);
      OpJe: o.branch = (reg_value(ra) == reg_value(rb));
      OpJg: o.branch = (reg_value(ra) > reg_value(rb));
      OpQuit: o.halt = 1'b1;
      default: ;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  // tvalid stays high between items unless the sender idles
  task automatic send_instr(logic [4:0] mode, logic [4:0] ra, logic [4:0] rb, logic [15:0] imm);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, imm, rb, ra, mode};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_outcomes = {pending_outcomes, execute_instr(mode, ra, rb, imm)};
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    outcome_t exp_o;
    if (rst_ni) begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_outcomes.size() == 0) begin
          report_mismatch("unexpected item", 32'(m_axis_tdata), 0);
        end else begin
          exp_o = pending_outcomes.pop_front();
          if (m_axis_tuser != exp_o.kind)
            report_mismatch("print_kind", 32'(m_axis_tuser), 32'(exp_o.kind));
          if (m_axis_tdata[15:0] != exp_o.value)
            report_mismatch("print_value", 32'(m_axis_tdata[15:0]), 32'(exp_o.value));
          if (m_axis_tdata[16] != exp_o.branch)
            report_mismatch("branch_taken", 32'(m_axis_tdata[16]), 32'(exp_o.branch));
          if (m_axis_tdata[17] != exp_o.halt)
            report_mismatch("halt", 32'(m_axis_tdata[17]), 32'(exp_o.halt));
          if (m_axis_tdata[19:18] != exp_o.err)
            report_mismatch("error", 32'(m_axis_tdata[19:18]), 32'(exp_o.err));
          if (m_axis_tdata[23:20] != 4'd0)
            report_mismatch("pad", 32'(m_axis_tdata[23:20]), 0);
        end
      end
    end
  end

  task automatic test_directed();
    send_instr(OpAdd, 5'd0, 5'd0, 16'd0);            // underflow on empty queue
    send_instr(OpPrint, 5'd0, 5'd0, 16'd0);
    send_instr(OpSetReg, 5'd0, 5'd0, 16'd0);
    send_instr(OpPrintChr, 5'd0, 5'd0, 16'd0);
    send_instr(OpPush, 5'd0, 5'd0, 16'hFFFF);
    send_instr(OpSub, 5'd0, 5'd0, 16'd0);            // one operand only
    send_instr(OpPush, 5'd0, 5'd0, 16'h0000);
    send_instr(OpDiv, 5'd0, 5'd0, 16'd0);            // divide by zero
    send_instr(OpPush, 5'd0, 5'd0, 16'h0000);
    send_instr(OpMod, 5'd0, 5'd0, 16'd0);            // mod by zero
    send_instr(OpSetReg, 5'd25, 5'd0, 16'd0);
    send_instr(OpPush, 5'd0, 5'd0, 16'h1234);
    send_instr(OpSetReg, 5'd31, 5'd0, 16'd0);        // write to missing register dropped
    send_instr(OpPrintReg, 5'd31, 5'd0, 16'd0);
    send_instr(OpGetReg, 5'd0, 5'd0, 16'd0);
    send_instr(OpPrintChr, 5'd0, 5'd0, 16'd0);
    send_instr(OpPrintRegChr, 5'd25, 5'd0, 16'd0);
    send_instr(OpJmp, 5'd0, 5'd0, 16'd0);
    send_instr(OpJz, 5'd0, 5'd0, 16'd0);
    send_instr(OpJe, 5'd0, 5'd31, 16'd0);
    send_instr(OpJg, 5'd25, 5'd0, 16'd0);
    send_instr(OpQuit, 5'd0, 5'd0, 16'd0);
    send_instr(OpLabel, 5'd0, 5'd0, 16'd0);
    send_instr(5'd31, 5'd31, 5'd31, 16'hFFFF);       // unknown mode
    send_instr(OpPrintReg, 5'd0, 5'd0, 16'd0);       // runs normally after quit
  endtask

  // fill to overflow, then pop some with arithmetic
  task automatic test_queue_full();
    repeat (QDepth - operands.size()) send_instr(OpPush, 5'd0, 5'd0, 16'($urandom));
    send_instr(OpPush, 5'd0, 5'd0, 16'hAAAA);
    send_instr(OpGetReg, 5'd3, 5'd0, 16'd0);
    repeat (30) send_instr(5'($urandom_range(OpAdd, OpMod)), 5'd0, 5'd0, 16'd0);
    send_instr(OpPrint, 5'd0, 5'd0, 16'd0);
  endtask

  task automatic test_random(int n);
    logic [4:0] mode;
    logic [15:0] imm;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) mode = 5'($urandom);
      else if (operands.size() < 2 && $urandom_range(2) != 0) mode = OpPush;
      else mode = 5'($urandom_range(0, 17));
      case ($urandom_range(3))
        0: imm = 16'($urandom_range(0, 3));
        1: imm = 16'hFFFF - 16'($urandom_range(0, 3));
        default: imm = 16'($urandom);
      endcase
      send_instr(mode, ($urandom_range(15) == 0) ? 5'($urandom) : 5'($urandom_range(0, 25)),
                 ($urandom_range(15) == 0) ? 5'($urandom) : 5'($urandom_range(0, 25)), imm);
    end
  endtask

  initial begin
    fail_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    foreach (regs[i]) regs[i] = '0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    drain_results();   // sender waits for every result
    test_random(70);
    send_idle_pct = 76;
    test_random(70);
    send_idle_pct = 0;
    recv_stall_pct = 76;
    test_random(70);
    send_idle_pct = 18;
    recv_stall_pct = 18;
    test_queue_full();
    test_random(40);
    drain_results();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* queue_machine_execute_unit.f */
+incdir+rtl
rtl/qmeu_pkg.sv
rtl/qmeu_ram.sv
rtl/qmeu_div.sv
rtl/qmeu_datapath.sv
rtl/qmeu_ctrl.sv
rtl/queue_machine_execute_unit.sv
rtl/qmeu_checker.sv
tb/sv/queue_machine_execute_unit_tb.sv
